// ===== rtl/nlmsaec_pkg.sv =====
// ----------------------------------------------------------------------------
// nlmsaec_pkg
// Shared types and constants of the NLMS echo canceller with talk detector.
// ----------------------------------------------------------------------------
package nlmsaec_pkg;

  localparam int MAX_TAPS_DEF    = 4096;
  localparam int MAX_FRAME_DEF   = 512;
  localparam logic [3:0] HANGOVER_FRAMES = 4'd10;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic        ENABLE_RST    = 1'b1;
  localparam logic [12:0] TAP_COUNT_RST = 13'd2560;
  localparam logic [15:0] STEP_RST      = 16'd9830;
  localparam logic [15:0] THRESH_RST    = 16'd21299;

  localparam logic [15:0] SMOOTH_OLD   = 16'd58982;
  localparam logic [15:0] SMOOTH_NEW   = 16'd6554;
  localparam logic [47:0] ACTIVE_FLOOR = 48'd1073;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE        = 2'd0,
    REG_TAP_COUNT     = 2'd1,
    REG_STEP_SIZE     = 2'd2,
    REG_DTD_THRESHOLD = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    TALK_IDLE   = 2'd0,
    TALK_FAR    = 2'd1,
    TALK_NEAR   = 2'd2,
    TALK_DOUBLE = 2'd3
  } talk_e;

  typedef struct packed {
    logic signed [15:0] far_sample;
    logic signed [15:0] near_sample;
    logic               frame_last;
  } in_t;

  typedef struct packed {
    logic signed [15:0] error_sample;
    logic [1:0]         talk_state;
    logic               frame_done;
  } out_t;

endpackage

// ===== rtl/nlmsaec_ram.sv =====
// ----------------------------------------------------------------------------
// nlmsaec_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module nlmsaec_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/nlms_echo_canceller_dtd.sv =====
// ----------------------------------------------------------------------------
// nlms_echo_canceller_dtd
// NLMS acoustic echo canceller with frame-based double-talk detector.
//
// Input channel (in_valid_i/in_ready_o, in_i) takes far/near sample pairs;
// output channel (out_valid_o/out_ready_i, out_o) returns one result per
// transaction. Configuration writes use cfg_valid_i/cfg_ready_o with a
// register index and data; they are always taken.
// One item is processed at a time. A cancelled sample takes two passes
// over the tap and weight RAMs plus a restoring divider; a frame end adds
// a detector update on a shared 24x16 multiplier.
// After reset both RAMs are cleared, one entry a cycle, while in_ready_o
// stays low.
// A finished result waits in the output register; while the receiver
// stalls, the next item is taken and worked on up to its own result.
// ----------------------------------------------------------------------------
module nlms_echo_canceller_dtd #(
  parameter int MAX_TAPS  = nlmsaec_pkg::MAX_TAPS_DEF,
  parameter int MAX_FRAME = nlmsaec_pkg::MAX_FRAME_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  nlmsaec_pkg::in_t                    in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output nlmsaec_pkg::out_t                   out_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [nlmsaec_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [nlmsaec_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int AW    = $clog2(MAX_TAPS);
  localparam int CNT_W = $clog2(MAX_TAPS + 1);
  localparam int POS_W = $clog2(MAX_FRAME + 1);
  localparam int ACC_W = 48 + CNT_W;
  localparam int EST_W = ACC_W - 28;
  localparam int PW_W  = 31 + CNT_W;
  localparam int DEN_W = PW_W + 1;
  localparam int NUM_W = 59;
  localparam int QC_W  = $clog2(NUM_W);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_P1, ST_ERR, ST_DIVL, ST_DIV, ST_GAIN,
    ST_P2, ST_SUMS, ST_DT, ST_OUT
  } state_e;

  state_e state_q;

  logic              en_q;
  logic [12:0]       tap_count_q;
  logic [15:0]       step_q;
  logic [15:0]       thr_q;

  logic [AW-1:0]     clr_q, head_q, tap_addr_q;
  logic [CNT_W-1:0]  cnt_q, n_q;
  logic [POS_W-1:0]  pos_q;
  logic signed [15:0] far_q, near_q, err_q, res_q;
  logic              last_q, done_q;

  logic              s1_q, s2_q, s3_q;
  logic [AW-1:0]     idx1_q, idx2_q, idx3_q;
  logic signed [47:0] prod_q;
  logic [30:0]       sq_q;
  logic signed [40:0] ph_q, pl_q;
  logic signed [31:0] wd2_q, wd3_q;
  logic signed [50:0] delta_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [PW_W-1:0]   pw_q;

  logic [DEN_W-1:0]  rem_q, den_q;
  logic [NUM_W-1:0]  dvd_q, quo_q;
  logic [QC_W-1:0]   qc_q;
  logic signed [48:0] gain_q;

  logic [47:0]       e_q [3];
  logic [47:0]       s_q [3];
  logic [1:0]        det_q;
  logic [3:0]        hang_q;
  logic [64:0]       dacc_q;
  logic [1:0]        ch_q;
  logic [2:0]        ph_q_dt;

  logic              out_valid_q;
  nlmsaec_pkg::out_t out_q;

  // ---------------------------------------------------------------- datapath
  logic              in_acc, issue, busy;
  logic [AW-1:0]     head_dec, tap_addr_inc;
  logic [CNT_W-1:0]  n_clamp;
  logic [15:0]       tap_rdata;
  logic [31:0]       w_rdata;
  logic signed [15:0] x_r;
  logic signed [31:0] w_r;

  logic              t_we, w_we;
  logic [AW-1:0]     t_waddr, w_waddr;
  logic [15:0]       t_wdata;
  logic [31:0]       w_wdata;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign head_dec     = (head_q == '0) ? AW'(MAX_TAPS - 1) : head_q - 1'b1;
  assign tap_addr_inc = (tap_addr_q == AW'(MAX_TAPS - 1)) ? '0 : tap_addr_q + 1'b1;
  assign issue = ((state_q == ST_P1) || (state_q == ST_P2)) && (cnt_q < n_q);
  assign busy  = s1_q || s2_q || s3_q;

  always_comb begin
    if (tap_count_q == '0) begin
      n_clamp = CNT_W'(1);
    end else if (int'(tap_count_q) > MAX_TAPS) begin
      n_clamp = CNT_W'(MAX_TAPS);
    end else begin
      n_clamp = CNT_W'(tap_count_q);
    end
  end

  assign x_r = $signed(tap_rdata);
  assign w_r = $signed(w_rdata);

  // error estimate and saturation
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [EST_W-1:0] est;
  logic signed [EST_W:0]   err_full;
  logic signed [15:0]      err_sat;

  assign acc_rnd  = acc_q + ACC_W'(64'sd134217728);
  assign est      = acc_rnd[ACC_W-1:28];
  assign err_full = (EST_W + 1)'(near_q) - (EST_W + 1)'(est);

  always_comb begin
    if (err_full > (EST_W + 1)'(32767)) begin
      err_sat = 16'sh7fff;
    end else if (err_full < -(EST_W + 1)'(32768)) begin
      err_sat = 16'sh8000;
    end else begin
      err_sat = err_full[15:0];
    end
  end

  // divider step
  logic [15:0]      mag;
  logic [31:0]      num_prod;
  logic [DEN_W:0]   trial, trial_sub;
  logic             ge;
  logic [47:0]      gmag;

  assign mag       = err_q[15] ? 16'(-err_q) : 16'(err_q);
  assign num_prod  = step_q * mag;
  assign trial     = {rem_q, dvd_q[NUM_W-1]};
  assign trial_sub = trial - {1'b0, den_q};
  assign ge        = (trial >= {1'b0, den_q});
  assign gmag      = (quo_q > NUM_W'(64'h8000_0000_0000)) ? 48'h8000_0000_0000 : quo_q[47:0];

  // weight update
  logic signed [24:0] g_hi, g_lo;
  logic signed [65:0] dsum;
  logic signed [51:0] wsum;
  logic signed [31:0] w_sat;

  assign g_hi = gain_q[48:24];
  assign g_lo = $signed({1'b0, gain_q[23:0]});
  assign dsum = (66'(ph_q) <<< 24) + 66'(pl_q);
  assign wsum = 52'(wd3_q) + 52'(delta_q);

  always_comb begin
    if (wsum > 52'sh7fff_ffff) begin
      w_sat = 32'sh7fff_ffff;
    end else if (wsum < -52'sh8000_0000) begin
      w_sat = 32'sh8000_0000;
    end else begin
      w_sat = wsum[31:0];
    end
  end

  // detector multiplier
  logic [23:0] mop_a;
  logic [15:0] mop_c;
  logic        mop_sh;
  logic [39:0] mul;
  logic [63:0] term;
  logic [48:0] smooth_r;
  logic [47:0] smooth_sat;
  logic        far_act, near_act, ratio_hi;

  always_comb begin
    mop_a  = '0;
    mop_c  = nlmsaec_pkg::SMOOTH_OLD;
    mop_sh = ph_q_dt[0];
    case (ch_q)
      2'd0: begin
        mop_a = ph_q_dt[1] ? (ph_q_dt[0] ? s_q[0][47:24] : s_q[0][23:0])
                           : (ph_q_dt[0] ? e_q[0][47:24] : e_q[0][23:0]);
        mop_c = ph_q_dt[1] ? nlmsaec_pkg::SMOOTH_NEW : nlmsaec_pkg::SMOOTH_OLD;
      end
      2'd1: begin
        mop_a = ph_q_dt[1] ? (ph_q_dt[0] ? s_q[1][47:24] : s_q[1][23:0])
                           : (ph_q_dt[0] ? e_q[1][47:24] : e_q[1][23:0]);
        mop_c = ph_q_dt[1] ? nlmsaec_pkg::SMOOTH_NEW : nlmsaec_pkg::SMOOTH_OLD;
      end
      2'd2: begin
        mop_a = ph_q_dt[1] ? (ph_q_dt[0] ? s_q[2][47:24] : s_q[2][23:0])
                           : (ph_q_dt[0] ? e_q[2][47:24] : e_q[2][23:0]);
        mop_c = ph_q_dt[1] ? nlmsaec_pkg::SMOOTH_NEW : nlmsaec_pkg::SMOOTH_OLD;
      end
      default: begin
        mop_a = ph_q_dt[0] ? e_q[1][47:24] : e_q[1][23:0];
        mop_c = thr_q;
      end
    endcase
  end

  assign mul        = mop_a * mop_c;
  assign term       = mop_sh ? {mul, 24'b0} : {24'b0, mul};
  assign smooth_r   = 49'((dacc_q + 65'd32768) >> 16);
  assign smooth_sat = smooth_r[48] ? 48'hffff_ffff_ffff : smooth_r[47:0];
  assign far_act    = e_q[0] > nlmsaec_pkg::ACTIVE_FLOOR;
  assign near_act   = e_q[1] > nlmsaec_pkg::ACTIVE_FLOOR;
  assign ratio_hi   = 65'({e_q[2], 15'b0}) > dacc_q;

  // ---------------------------------------------------------------- RAMs
  always_comb begin
    t_we    = 1'b0;
    t_waddr = head_dec;
    t_wdata = in_i.far_sample;
    w_we    = 1'b0;
    w_waddr = idx3_q;
    w_wdata = w_sat;
    if (state_q == ST_CLEAR) begin
      t_we    = 1'b1;
      t_waddr = clr_q;
      t_wdata = '0;
      w_we    = 1'b1;
      w_waddr = clr_q;
      w_wdata = '0;
    end else begin
      t_we = in_acc && en_q && (pos_q < POS_W'(MAX_FRAME));
      w_we = (state_q == ST_P2) && s3_q;
    end
  end

  nlmsaec_ram #(.WIDTH(16), .DEPTH(MAX_TAPS)) u_tap_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .re_i    (issue),
    .raddr_i (tap_addr_q),
    .rdata_o (tap_rdata)
  );

  nlmsaec_ram #(.WIDTH(32), .DEPTH(MAX_TAPS)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .re_i    (issue),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (w_rdata)
  );

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q        <= nlmsaec_pkg::ENABLE_RST;
      tap_count_q <= nlmsaec_pkg::TAP_COUNT_RST;
      step_q      <= nlmsaec_pkg::STEP_RST;
      thr_q       <= nlmsaec_pkg::THRESH_RST;
    end else if (cfg_valid_i) begin
      case (nlmsaec_pkg::cfg_reg_e'(cfg_index_i))
        nlmsaec_pkg::REG_ENABLE:        en_q        <= cfg_data_i[0];
        nlmsaec_pkg::REG_TAP_COUNT:     tap_count_q <= cfg_data_i[12:0];
        nlmsaec_pkg::REG_STEP_SIZE:     step_q      <= cfg_data_i;
        nlmsaec_pkg::REG_DTD_THRESHOLD: thr_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
      s2_q <= 1'b0;
      s3_q <= 1'b0;
    end else begin
      s1_q <= issue;
      s2_q <= s1_q;
      s3_q <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q  <= cnt_q[AW-1:0];
    idx2_q  <= idx1_q;
    idx3_q  <= idx2_q;
    prod_q  <= w_r * x_r;
    sq_q    <= 31'(32'(x_r * x_r));
    ph_q    <= g_hi * x_r;
    pl_q    <= g_lo * x_r;
    wd2_q   <= w_r;
    wd3_q   <= wd2_q;
    delta_q <= dsum[65:15];
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      head_q      <= '0;
      tap_addr_q  <= '0;
      cnt_q       <= '0;
      n_q         <= '0;
      pos_q       <= '0;
      det_q       <= nlmsaec_pkg::TALK_IDLE;
      hang_q      <= '0;
      ch_q        <= '0;
      ph_q_dt     <= '0;
      qc_q        <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        e_q[k] <= '0;
        s_q[k] <= '0;
      end
    end else begin
      if (out_ready_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      if (issue) begin
        cnt_q      <= cnt_q + 1'b1;
        tap_addr_q <= tap_addr_inc;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(MAX_TAPS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            far_q  <= in_i.far_sample;
            near_q <= in_i.near_sample;
            last_q <= in_i.frame_last;
            res_q  <= in_i.near_sample;
            done_q <= 1'b0;
            if (!en_q) begin
              if (in_i.frame_last) begin
                pos_q <= '0;
                for (int k = 0; k < 3; k++) begin
                  s_q[k] <= '0;
                end
              end
              state_q <= ST_OUT;
            end else if (pos_q < POS_W'(MAX_FRAME)) begin
              head_q     <= head_dec;
              tap_addr_q <= head_dec;
              pos_q      <= pos_q + 1'b1;
              n_q        <= n_clamp;
              cnt_q      <= '0;
              acc_q      <= '0;
              pw_q       <= '0;
              state_q    <= ST_P1;
            end else if (in_i.frame_last) begin
              ch_q    <= '0;
              ph_q_dt <= '0;
              state_q <= ST_DT;
            end else begin
              state_q <= ST_OUT;
            end
          end
        end
        ST_P1: begin
          if (s2_q) begin
            acc_q <= acc_q + ACC_W'(prod_q);
            pw_q  <= pw_q + PW_W'(sq_q);
          end
          if (!issue && !busy) begin
            state_q <= ST_ERR;
          end
        end
        ST_ERR: begin
          err_q   <= err_sat;
          state_q <= ST_DIVL;
        end
        ST_DIVL: begin
          rem_q   <= '0;
          dvd_q   <= {num_prod[30:0], 28'b0};
          den_q   <= DEN_W'(pw_q) + 1'b1;
          quo_q   <= '0;
          qc_q    <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          rem_q <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
          quo_q <= {quo_q[NUM_W-2:0], ge};
          dvd_q <= dvd_q << 1;
          qc_q  <= qc_q + 1'b1;
          if (qc_q == QC_W'(NUM_W - 1)) begin
            state_q <= ST_GAIN;
          end
        end
        ST_GAIN: begin
          gain_q     <= err_q[15] ? -$signed({1'b0, gmag}) : $signed({1'b0, gmag});
          tap_addr_q <= head_q;
          cnt_q      <= '0;
          state_q    <= ST_P2;
        end
        ST_P2: begin
          if (!issue && !busy) begin
            state_q <= ST_SUMS;
          end
        end
        ST_SUMS: begin
          s_q[0] <= s_q[0] + 48'(32'(far_q * far_q));
          s_q[1] <= s_q[1] + 48'(32'(near_q * near_q));
          s_q[2] <= s_q[2] + 48'(32'(err_q * err_q));
          res_q  <= err_q;
          if (last_q) begin
            ch_q    <= '0;
            ph_q_dt <= '0;
            state_q <= ST_DT;
          end else begin
            state_q <= ST_OUT;
          end
        end
        ST_DT: begin
          pos_q <= '0;
          if (ch_q != 2'd3) begin
            if (ph_q_dt == 3'd4) begin
              case (ch_q)
                2'd0: e_q[0] <= smooth_sat;
                2'd1: e_q[1] <= smooth_sat;
                default: e_q[2] <= smooth_sat;
              endcase
              case (ch_q)
                2'd0: s_q[0] <= '0;
                2'd1: s_q[1] <= '0;
                default: s_q[2] <= '0;
              endcase
              ch_q    <= ch_q + 1'b1;
              ph_q_dt <= '0;
            end else begin
              dacc_q  <= (ph_q_dt == 3'd0) ? 65'(term) : dacc_q + 65'(term);
              ph_q_dt <= ph_q_dt + 1'b1;
            end
          end else if (ph_q_dt != 3'd2) begin
            dacc_q  <= (ph_q_dt == 3'd0) ? 65'(term) : dacc_q + 65'(term);
            ph_q_dt <= ph_q_dt + 1'b1;
          end else begin
            if (ratio_hi && far_act && near_act) begin
              det_q  <= nlmsaec_pkg::TALK_DOUBLE;
              hang_q <= nlmsaec_pkg::HANGOVER_FRAMES;
            end else if (hang_q != '0) begin
              hang_q <= hang_q - 1'b1;
            end else if (far_act && !near_act) begin
              det_q <= nlmsaec_pkg::TALK_FAR;
            end else if (!far_act && near_act) begin
              det_q <= nlmsaec_pkg::TALK_NEAR;
            end else begin
              det_q <= nlmsaec_pkg::TALK_IDLE;
            end
            done_q  <= 1'b1;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.error_sample <= res_q;
            out_q.talk_state   <= det_q;
            out_q.frame_done   <= done_q;
            out_valid_q        <= 1'b1;
            state_q            <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- checks
  a_accept_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !busy)
    else $error("input taken with tap pipeline busy");

  a_no_wr_pass1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_P1) |-> !w_we)
    else $error("weight write during estimate pass");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(MAX_FRAME))
    else $error("frame position overrun");

  a_hang_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hang_q <= nlmsaec_pkg::HANGOVER_FRAMES)
    else $error("hangover count overrun");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVL) |=> (state_q == ST_DIV) && (qc_q == '0))
    else $error("divider start lost");

endmodule

// ===== sim/tb_nlms_echo_canceller_dtd.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nlms_echo_canceller_dtd
// Self-checking bench for the NLMS echo canceller and its double-talk
// detector. A table of directed rows walks the register extremes, bypass and
// sample extremes. Random frames of echo-like traffic then run under several
// register settings. Every output transaction is checked field by field
// against an in-bench model of the filter, its adaptation and the detector,
// or against a given result for a typed row. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_nlms_echo_canceller_dtd;

  localparam int NTAP = 4096;
  localparam int NFRAME = 512;
  localparam int STALL_LIMIT = 40000;
  localparam longint GAIN_CAP = 64'sd1 <<< 47;
  localparam bit [63:0] E48_MAX = 64'hFFFF_FFFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  nlmsaec_pkg::in_t in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  nlmsaec_pkg::out_t out_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [nlmsaec_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [nlmsaec_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  nlms_echo_canceller_dtd dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // canceller state held by the bench
  bit en_m;
  bit [12:0] taps_m;
  bit [15:0] mu_m, thr_m;
  shortint tap_line_m[NTAP];
  int weight_m[NTAP];
  bit [63:0] frame_sum_m[3], energy_m[3];
  nlmsaec_pkg::talk_e talk_m;
  int hang_m, fpos_m;

  nlmsaec_pkg::out_t expected_q[$];
  int fails = 0;
  bit no_stall = 1'b0, no_gap = 1'b0;
  int stall_cnt = 0;
  int quiet = 0;

  function automatic void update_detector();
    bit [63:0] s;
    bit far_act, near_act, ratio_hi;
    for (int k = 0; k < 3; k++) begin
      s = frame_sum_m[k] > E48_MAX ? E48_MAX : frame_sum_m[k];
      s = (energy_m[k] * 64'd58982 + s * 64'd6554 + 64'd32768) >> 16;
      energy_m[k] = s > E48_MAX ? E48_MAX : s;
      frame_sum_m[k] = 0;
    end
    far_act = energy_m[0] > 64'd1073;
    near_act = energy_m[1] > 64'd1073;
    ratio_hi = (energy_m[2] << 15) > (64'(thr_m) * energy_m[1]);
    if (ratio_hi && far_act && near_act) begin
      talk_m = nlmsaec_pkg::TALK_DOUBLE;
      hang_m = nlmsaec_pkg::HANGOVER_FRAMES;
    end else if (hang_m > 0) begin
      hang_m--;
    end else if (far_act && !near_act) begin
      talk_m = nlmsaec_pkg::TALK_FAR;
    end else if (!far_act && near_act) begin
      talk_m = nlmsaec_pkg::TALK_NEAR;
    end else begin
      talk_m = nlmsaec_pkg::TALK_IDLE;
    end
  endfunction

  function automatic longint cancel_echo(longint far, longint near);
    int n;
    longint acc, est, err, gain, w;
    bit [63:0] pwr, mag, num;
    n = taps_m == 0 ? 1 : (taps_m > NTAP ? NTAP : taps_m);
    for (int i = NTAP - 1; i > 0; i--) tap_line_m[i] = tap_line_m[i-1];
    tap_line_m[0] = shortint'(far);
    acc = 0;
    pwr = 0;
    for (int i = 0; i < n; i++) begin
      acc += longint'(weight_m[i]) * longint'(tap_line_m[i]);
      pwr += 64'(longint'(tap_line_m[i]) * longint'(tap_line_m[i]));
    end
    est = (acc + (64'sd1 <<< 27)) >>> 28;
    err = near - est;
    if (err > 32767) err = 32767;
    if (err < -32768) err = -32768;
    mag = err < 0 ? 64'(-err) : 64'(err);
    num = (64'(mu_m) * mag) << 28;
    num = num / (pwr + 64'd1);
    gain = num > 64'(GAIN_CAP) ? GAIN_CAP : longint'(num);
    if (err < 0) gain = -gain;
    for (int i = 0; i < n; i++) begin
      w = longint'(weight_m[i]) + ((gain * longint'(tap_line_m[i])) >>> 15);
      if (w > 64'sd2147483647) w = 64'sd2147483647;
      if (w < -64'sd2147483648) w = -64'sd2147483648;
      weight_m[i] = int'(w);
    end
    frame_sum_m[0] += 64'(far * far);
    frame_sum_m[1] += 64'(near * near);
    frame_sum_m[2] += 64'(err * err);
    return err;
  endfunction

  function automatic nlmsaec_pkg::out_t predict_cancel(nlmsaec_pkg::in_t it);
    nlmsaec_pkg::out_t r;
    longint res;
    res = longint'(it.near_sample);
    r.frame_done = 1'b0;
    if (en_m) begin
      if (fpos_m < NFRAME) begin
        res = cancel_echo(longint'(it.far_sample), longint'(it.near_sample));
        fpos_m++;
      end
      if (it.frame_last) begin
        update_detector();
        fpos_m = 0;
        r.frame_done = 1'b1;
      end
    end else if (it.frame_last) begin
      for (int k = 0; k < 3; k++) frame_sum_m[k] = 0;
      fpos_m = 0;
    end
    r.error_sample = res[15:0];
    r.talk_state = talk_m;
    return r;
  endfunction

  // output side: random stall per transaction, compare in order
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result err=%0d talk=%0d done=%0d", $time,
                 out_o.error_sample, out_o.talk_state, out_o.frame_done);
        fails++;
      end else begin
        if (out_o.error_sample !== expected_q[0].error_sample) begin
          $display("%0t: error_sample expected %0d actual %0d", $time,
                   expected_q[0].error_sample, out_o.error_sample);
          fails++;
        end
        if (out_o.talk_state !== expected_q[0].talk_state) begin
          $display("%0t: talk_state expected %0d actual %0d", $time,
                   expected_q[0].talk_state, out_o.talk_state);
          fails++;
        end
        if (out_o.frame_done !== expected_q[0].frame_done) begin
          $display("%0t: frame_done expected %0d actual %0d", $time,
                   expected_q[0].frame_done, out_o.frame_done);
          fails++;
        end
        void'(expected_q.pop_front());
      end
    end
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_ready_i <= (stall_cnt == 1);
    end else if (!out_ready_i || out_valid_o) begin
      automatic int n = no_stall ? 0 : $urandom_range(0, 14);
      stall_cnt <= n;
      out_ready_i <= (n == 0);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("nlms_echo_canceller_dtd verification failed");
      $finish;
    end
  end

  task automatic send_sample(nlmsaec_pkg::in_t it, bit typed, nlmsaec_pkg::out_t want);
    int gap;
    nlmsaec_pkg::out_t r;
    gap = no_gap ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    r = predict_cancel(it);
    expected_q.push_back(typed ? want : r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(nlmsaec_pkg::cfg_reg_e idx, bit [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      nlmsaec_pkg::REG_ENABLE:        en_m = val[0];
      nlmsaec_pkg::REG_TAP_COUNT:     taps_m = val[12:0];
      nlmsaec_pkg::REG_STEP_SIZE:     mu_m = val;
      nlmsaec_pkg::REG_DTD_THRESHOLD: thr_m = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  typedef struct {
    bit is_cfg;
    nlmsaec_pkg::cfg_reg_e idx;
    bit [15:0] val;
    nlmsaec_pkg::in_t it;
    bit typed;
    nlmsaec_pkg::out_t want;
  } row_t;

  function automatic row_t smp(int f, int n, bit l);
    row_t r;
    r = '{1'b0, nlmsaec_pkg::REG_ENABLE, 16'd0, '{16'(f), 16'(n), l}, 1'b0, '0};
    return r;
  endfunction

  function automatic row_t wr(nlmsaec_pkg::cfg_reg_e i, int v);
    row_t r;
    r = '{1'b1, i, 16'(v), '0, 1'b0, '0};
    return r;
  endfunction

  // echo-like frame: near follows far at random level, sometimes with talk
  task automatic send_frame(int len);
    int f, n, sh;
    bit talk;
    nlmsaec_pkg::in_t it;
    sh = $urandom_range(0, 4);
    talk = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        f = $signed(16'($urandom()));
        n = $signed(16'($urandom()));
      end else begin
        f = $signed(16'($urandom())) >>> $urandom_range(0, 6);
        n = (f >>> sh) + (talk ? ($signed(16'($urandom())) >>> 2) : 0);
      end
      it = '{16'(f), 16'(n), (i == len - 1)};
      send_sample(it, 1'b0, '0);
    end
  endtask

  initial begin
    row_t rows[$];
    en_m = nlmsaec_pkg::ENABLE_RST;
    taps_m = nlmsaec_pkg::TAP_COUNT_RST;
    mu_m = nlmsaec_pkg::STEP_RST;
    thr_m = nlmsaec_pkg::THRESH_RST;
    foreach (tap_line_m[i]) tap_line_m[i] = 0;
    foreach (weight_m[i]) weight_m[i] = 0;
    for (int k = 0; k < 3; k++) begin
      frame_sum_m[k] = 0;
      energy_m[k] = 0;
    end
    talk_m = nlmsaec_pkg::TALK_IDLE;
    hang_m = 0;
    fpos_m = 0;

    rows.push_back(smp(32767, -32768, 1'b0));
    rows[0].typed = 1'b1;
    rows[0].want = '{-16'sd32768, nlmsaec_pkg::TALK_IDLE, 1'b0};
    rows.push_back(smp(-32768, 32767, 1'b1));
    rows.push_back(wr(nlmsaec_pkg::REG_TAP_COUNT, 0));
    rows.push_back(wr(nlmsaec_pkg::REG_STEP_SIZE, 65535));
    rows.push_back(smp(32767, 32767, 1'b0));
    rows.push_back(smp(-32768, -32768, 1'b0));
    rows.push_back(smp(0, 0, 1'b1));
    rows.push_back(wr(nlmsaec_pkg::REG_ENABLE, 0));
    rows.push_back(smp(-32768, 12345, 1'b0));
    rows.push_back(smp(32767, -1, 1'b1));
    rows.push_back(wr(nlmsaec_pkg::REG_ENABLE, 1));
    rows.push_back(wr(nlmsaec_pkg::REG_STEP_SIZE, 0));
    rows.push_back(wr(nlmsaec_pkg::REG_DTD_THRESHOLD, 0));
    rows.push_back(smp(20000, 30000, 1'b1));
    rows.push_back(wr(nlmsaec_pkg::REG_DTD_THRESHOLD, 65535));
    rows.push_back(wr(nlmsaec_pkg::REG_TAP_COUNT, 8191));
    rows.push_back(wr(nlmsaec_pkg::REG_STEP_SIZE, 32768));
    rows.push_back(smp(-32768, 32767, 1'b0));
    rows.push_back(smp(1, -1, 1'b1));
    rows.push_back(wr(nlmsaec_pkg::REG_TAP_COUNT, 4096));
    rows.push_back(smp(-1, 0, 1'b1));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        drain();
        write_reg(rows[i].idx, rows[i].val);
      end else begin
        send_sample(rows[i].it, rows[i].typed, rows[i].want);
      end
    end

    for (int ph = 0; ph < 9; ph++) begin
      drain();
      no_gap = (ph % 3 == 1);
      no_stall = (ph % 4 == 2);
      write_reg(nlmsaec_pkg::REG_ENABLE, 16'($urandom_range(0, 5) != 0));
      write_reg(nlmsaec_pkg::REG_TAP_COUNT, 16'(ph == 4 ? 4096 : $urandom_range(1, 24)));
      write_reg(nlmsaec_pkg::REG_STEP_SIZE, 16'(ph == 0 ? 65535 : $urandom_range(0, 65535)));
      write_reg(nlmsaec_pkg::REG_DTD_THRESHOLD, 16'(ph == 1 ? 0 : $urandom_range(0, 65535)));
      if (ph == 4)
        send_frame(3);
      else
        for (int fr = 0; fr < 3; fr++) send_frame($urandom_range(1, 5));
    end

    drain();
    no_gap = 1'b0;
    no_stall = 1'b0;
    write_reg(nlmsaec_pkg::REG_ENABLE, 16'd1);
    write_reg(nlmsaec_pkg::REG_TAP_COUNT, 16'd1);
    send_frame(8);
    send_frame(4);

    drain();
    repeat (200) @(posedge clk_i);
    if (fails == 0)
      $display("nlms_echo_canceller_dtd verification clean");
    else
      $display("nlms_echo_canceller_dtd verification failed");
    $finish;
  end

endmodule
